@@ design/ptb_pkg.sv @@
package ptb_pkg;

  // Default sizing of the timer bank
  localparam int NUM_SLOTS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 32;

  // Stream field widths
  localparam int OP_W        = 2;
  localparam int SLOT_ID_W   = 8;
  localparam int PERIOD_W    = 32;
  localparam int MASK_W      = 8;
  localparam int MASK_IDX_W  = 3;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 8;
  localparam int OUT_DATA_W  = 16;

  // Operation codes carried in tuser
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

endpackage

@@ design/ptb_ram.sv @@
module ptb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/periodic_timer_bank.sv @@
// Bank of periodic timer slots.
// Input stream (s_axis): tuser carries the operation (tick, start, stop), tdata
// the slot number and the period. Output stream (m_axis): one transaction per
// input transaction, holding the fired mask and the accepted flag.
// A start loads a slot with a nonzero period and clears its count; a stop
// disables a slot. A tick advances every enabled slot and reports which ones
// reached their period.
// Periods and counts live in one RAM word per slot; enable bits are flops.
// One transaction is handled at a time. A tick walks the RAM one slot per
// cycle with a read-modify-write, then passes through a drain state and a
// done state; start, stop and unused codes go straight to the done state.
// The done state loads the result into the output register, after which the
// next input is taken. The single RAM read port sets the pace of the walk.
// Reset clears all enable bits, so every slot starts disabled; RAM contents
// need no clearing since a start writes both period and count.
// The result sits in an output register; a new input is accepted while it
// waits, and the block holds its next result until the receiver takes the
// pending one.
module periodic_timer_bank #(
  parameter int NUM_SLOTS   = ptb_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] slot_id, [39:8] period
  input  logic [ptb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] op, [7:2] zero
  input  logic [ptb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] fired_mask, [8] accepted, [15:9] zero
  output logic [ptb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ptb_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WORD_W = 2 * COUNT_WIDTH;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [NUM_SLOTS-1:0]   enabled_q;
  logic [SLOT_W-1:0]      idx_q;
  logic                   rvalid_q;
  logic [SLOT_W-1:0]      ridx_q;
  logic [MASK_W-1:0]      fired_q;
  logic                   acc_q;
  logic                   m_valid_q;
  logic [MASK_W-1:0]      m_fired_q;
  logic                   m_acc_q;

  logic                   in_accept;
  logic [OP_W-1:0]        in_op;
  logic [SLOT_ID_W-1:0]   in_slot;
  logic [COUNT_WIDTH-1:0] in_period;
  logic                   slot_in_range;
  logic                   start_ok;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [WORD_W-1:0]      ram_rdata;

  logic [COUNT_WIDTH-1:0] rd_period;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   expire;
  logic                   slot_on;
  logic [SLOT_ID_W-1:0]   ridx_ext;
  logic [MASK_W-1:0]      fire_bit;

  // Input decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tuser[OP_W-1:0];
  assign in_slot       = s_axis_tdata[SLOT_ID_W-1:0];
  assign in_period     = COUNT_WIDTH'(s_axis_tdata[SLOT_ID_W +: PERIOD_W]);
  assign slot_in_range = ({1'b0, in_slot} < (SLOT_ID_W + 1)'(NUM_SLOTS));
  assign start_ok      = slot_in_range && (in_period != '0);

  // Slot update from the RAM word read in the previous cycle
  assign rd_period = ram_rdata[WORD_W-1:COUNT_WIDTH];
  assign rd_count  = ram_rdata[COUNT_WIDTH-1:0];
  assign cnt_inc   = rd_count + COUNT_WIDTH'(1);
  assign expire    = (cnt_inc >= rd_period);
  assign slot_on   = enabled_q[ridx_q];
  assign ridx_ext  = SLOT_ID_W'(ridx_q);

  always_comb begin
    fire_bit = '0;
    if (rvalid_q && slot_on && expire && (ridx_ext < SLOT_ID_W'(MASK_W))) begin
      fire_bit = MASK_W'(1) << ridx_ext[MASK_IDX_W-1:0];
    end
  end

  // RAM port control: start writes in idle, the walk writes back behind its reads
  assign ram_re = (state_q == ST_WALK);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ridx_q;
    ram_wdata = {rd_period, (expire ? {COUNT_WIDTH{1'b0}} : cnt_inc)};
    if (in_accept && (in_op == OP_START) && start_ok) begin
      ram_we    = 1'b1;
      ram_waddr = SLOT_W'(in_slot);
      ram_wdata = {in_period, {COUNT_WIDTH{1'b0}}};
    end else if (rvalid_q && slot_on) begin
      ram_we = 1'b1;
    end
  end

  ptb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS),
    .AW    (SLOT_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer, slot enables and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      enabled_q <= '0;
      idx_q     <= '0;
      rvalid_q  <= 1'b0;
      ridx_q    <= '0;
      fired_q   <= '0;
      acc_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_fired_q <= '0;
      m_acc_q   <= 1'b0;
    end else begin
      rvalid_q <= (state_q == ST_WALK);
      ridx_q   <= idx_q;
      if (rvalid_q) begin
        fired_q <= fired_q | fire_bit;
      end
      // Pending result taken; a result loaded from done overrides this
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            fired_q <= '0;
            state_q <= (in_op == OP_TICK) ? ST_WALK : ST_DONE;
            case (in_op)
              OP_TICK: begin
                acc_q   <= 1'b1;
                idx_q   <= '0;
              end
              OP_START: begin
                acc_q <= start_ok;
                if (start_ok) begin
                  enabled_q[SLOT_W'(in_slot)] <= 1'b1;
                end
              end
              OP_STOP: begin
                acc_q <= 1'b1;
                if (slot_in_range) begin
                  enabled_q[SLOT_W'(in_slot)] <= 1'b0;
                end
              end
              default: begin
                acc_q <= 1'b0;
              end
            endcase
          end
        end
        ST_WALK: begin
          idx_q <= idx_q + SLOT_W'(1);
          if (idx_q == LAST_SLOT) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_fired_q <= fired_q;
            m_acc_q   <= acc_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - MASK_W - 1)'(0), m_acc_q, m_fired_q};

endmodule
